// ----- rtl/mrt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the monocular range / time-to-collision unit.
// No dependencies; imported by every module of the block.
package mrt_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SLOT, ST_RMUL, ST_RDIV, ST_RWAIT, ST_BINIT, ST_CORDIC, ST_BFIN,
    ST_SCHK, ST_SDIV, ST_SWAIT, ST_TMUL1, ST_TCHK, ST_TMUL2, ST_TMUL3, ST_TDIV,
    ST_TWAIT, ST_RISK, ST_FEND, ST_OUT
  } mrt_state_t;

  localparam logic [1:0] REQ_TRACK = 2'd0;
  localparam logic [1:0] REQ_LAST  = 2'd1;
  localparam logic [1:0] REQ_EMPTY = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [2:0] CFG_HORIZON  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_FOCAL    = 3'd2;
  localparam logic [2:0] CFG_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_CRIT_TTC = 3'd4;
  localparam logic [2:0] CFG_WARN_RNG = 3'd5;

  localparam logic [1:0] RISK_SAFE = 2'd0;
  localparam logic [1:0] RISK_WARN = 2'd1;
  localparam logic [1:0] RISK_CRIT = 2'd2;

  localparam logic [17:0] RANGE_MAX   = 18'd160000;
  localparam logic [17:0] TTC_NONE    = 18'd159984;
  localparam logic [17:0] NEAR_RANGE  = 18'd320;
  localparam logic [13:0] BEARING_MAX = 14'd5760;
  localparam logic [22:0] SPEED_MAX   = 23'd8388607;
  localparam logic signed [6:0] RUDDER_LEFT  = -7'sd45;
  localparam logic signed [6:0] RUDDER_RIGHT = 7'sd45;

  localparam logic [4:0] CORDIC_LAST = 5'd17;
  localparam logic [15:0] SPEED_SCALE = 16'd16000;
  localparam logic [15:0] TTC_GATE    = 16'd625;
  localparam logic [15:0] TTC_DEN     = 16'd125;

  localparam int DIV_NW = 36;
  localparam int DIV_DW = 25;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [21:0] cordic_angle(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117306;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mrt_div.sv -----
`timescale 1ns / 1ps
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on mrt_pkg for the operand widths.
module mrt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mrt_pkg::DIV_NW-1:0] dividend,
  input  logic [mrt_pkg::DIV_DW-1:0] divisor,
  output logic                      done,
  output logic [mrt_pkg::DIV_NW-1:0] quotient
);
  import mrt_pkg::*;

  logic                busy;
  logic [5:0]          cnt;
  logic [DIV_DW-1:0]   rem;
  logic [DIV_DW-1:0]   dsr;
  logic [DIV_DW:0]     trial;
  logic                qbit;

  assign trial = {rem, quotient[DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= qbit ? DIV_DW'(trial - {1'b0, dsr}) : trial[DIV_DW-1:0];
      quotient <= {quotient[DIV_NW-2:0], qbit};
    end
  end

endmodule

// ----- rtl/monocular_range_ttc_risk_unit.sv -----
`timescale 1ns / 1ps
// Top level: range, bearing, closing speed, time to collision and frame risk.
// Depends on mrt_pkg and mrt_div (shared divider).
// Steps for a closing track word with history: slot, range multiply and divide, CORDIC,
// speed divide, TTC multiplies and divide, risk, output; a last word adds frame end.
// No history skips speed and TTC, a receding track TTC, a saturated range the range divide,
// a centred box CORDIC; empty: frame end, clear: output; ids >= TRACK_SLOTS fold at slot.
// One word at a time, next word taken the cycle after the result loads. Sync reset: defaults.
module monocular_range_ttc_risk_unit #(
  parameter int TRACK_SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [7:0]         track_no,
  input  logic [15:0]        box_left,
  input  logic [15:0]        box_right,
  input  logic [15:0]        box_bottom,
  input  logic [15:0]        frame_interval,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         track_no_out,
  output logic [17:0]        range_est,
  output logic signed [13:0] bearing_est,
  output logic signed [23:0] closing_speed,
  output logic [17:0]        collision_time,
  output logic               frame_done,
  output logic [1:0]         risk_level,
  output logic signed [6:0]  rudder_hint
);
  import mrt_pkg::*;

  localparam int SW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

  mrt_state_t state, state_next;

  // configuration
  logic [15:0] horizon_row, camera_height, focal_length;
  logic [12:0] image_width;
  logic [17:0] critical_ttc, warning_distance;

  // latched word
  logic [1:0]  req;
  logic [7:0]  id_work;
  logic [15:0] left_q, right_q, bottom_q, dt;
  logic [SW-1:0] slot;

  // track history
  logic [17:0] mem [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] vld;
  logic [17:0] stored;
  logic        hist_vld;

  // shared multiplier
  logic [17:0] mul_a;
  logic [15:0] mul_b;
  logic [33:0] prod;

  // divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;

  // cordic
  logic signed [33:0] cx, cy;
  logic signed [24:0] ca;
  logic [4:0]         step;
  logic               bneg;

  logic signed [16:0] dsub;
  logic signed [18:0] delta;
  logic [17:0]        dmag;
  logic [35:0]        ttc_num;

  // results
  logic [7:0]         res_id;
  logic [17:0]        res_rng, res_ttc;
  logic signed [13:0] res_brg;
  logic signed [23:0] res_spd;
  logic               res_done;
  logic [1:0]         res_risk;
  logic signed [6:0]  res_rud;

  // frame state
  logic [1:0]         frame_risk;
  logic [17:0]        least_ttc;
  logic signed [13:0] crit_brg;

  logic accept, load_out, hist, slot_over;
  logic [17:0]        ymag;
  logic signed [17:0] ydiff;
  logic [16:0]        ysum;
  logic [23:0]        ca_round;
  logic [13:0]        bq;

  assign slot      = SW'(id_work);
  assign slot_over = (int'(id_work) >= TRACK_SLOTS);
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state == ST_OUT) && (!out_valid || !out_stall);
  assign dsub      = $signed({1'b0, bottom_q}) - $signed({1'b0, horizon_row});
  assign delta     = $signed({1'b0, stored}) - $signed({1'b0, res_rng});
  assign dmag      = delta[18] ? 18'(-delta) : delta[17:0];
  assign hist      = hist_vld && (stored != 18'd0) && (dt != 16'd0);
  assign ysum      = {1'b0, left_q} + {1'b0, right_q};
  assign ydiff     = $signed({1'b0, ysum}) - $signed({1'b0, image_width, 4'b0});
  assign ymag      = ydiff[17] ? 18'(-ydiff) : 18'(ydiff);
  assign ca_round  = ca[23:0] + 24'd512;
  assign bq        = ca[24] ? 14'd0 : ca_round[23:10];

  mrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_CLEAR: state_next = ST_OUT;
            REQ_EMPTY: state_next = ST_FEND;
            default:   state_next = ST_SLOT;
          endcase
        end
      end
      ST_SLOT:   state_next = slot_over ? ST_SLOT : ST_RMUL;
      ST_RMUL:   state_next = ST_RDIV;
      ST_RDIV:   state_next = (dsub <= 17'sd16) ? ST_BINIT : ST_RWAIT;
      ST_RWAIT:  state_next = div_done ? ST_BINIT : ST_RWAIT;
      ST_BINIT:  state_next = (ymag == 18'd0) ? ST_SCHK : ST_CORDIC;
      ST_CORDIC: state_next = (step == CORDIC_LAST) ? ST_BFIN : ST_CORDIC;
      ST_BFIN:   state_next = ST_SCHK;
      ST_SCHK:   state_next = hist ? ST_SDIV : ST_RISK;
      ST_SDIV:   state_next = ST_SWAIT;
      ST_SWAIT:  state_next = div_done ? ST_TMUL1 : ST_SWAIT;
      ST_TMUL1:  state_next = ST_TCHK;
      ST_TCHK: begin
        if (!delta[18] && dmag != 18'd0 && prod > {18'd0, dt}) state_next = ST_TMUL2;
        else state_next = ST_RISK;
      end
      ST_TMUL2:  state_next = ST_TMUL3;
      ST_TMUL3:  state_next = ST_TDIV;
      ST_TDIV:   state_next = ST_TWAIT;
      ST_TWAIT:  state_next = div_done ? ST_RISK : ST_TWAIT;
      ST_RISK:   state_next = (req == REQ_LAST) ? ST_FEND : ST_OUT;
      ST_FEND:   state_next = ST_OUT;
      ST_OUT:    state_next = load_out ? ST_IDLE : ST_OUT;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs and operand selection
  always_comb begin
    in_stall  = (state != ST_IDLE);
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_RMUL: begin
        mul_a = {2'b0, camera_height};
        mul_b = focal_length;
      end
      ST_RDIV: begin
        div_start = (dsub > 17'sd16);
        div_num   = DIV_NW'(prod[31:0]) + DIV_NW'({dsub[15:0], 3'b0});
        div_den   = DIV_DW'({dsub[15:0], 4'b0});
      end
      ST_SCHK: begin
        mul_a = dmag;
        mul_b = SPEED_SCALE;
      end
      ST_SDIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(prod);
        div_den   = DIV_DW'(dt);
      end
      ST_TMUL1: begin
        mul_a = dmag;
        mul_b = TTC_GATE;
      end
      ST_TMUL2: begin
        mul_a = res_rng;
        mul_b = dt;
      end
      ST_TMUL3: begin
        mul_a = dmag;
        mul_b = TTC_DEN;
      end
      ST_TDIV: begin
        div_start = 1'b1;
        div_num   = ttc_num + DIV_NW'(prod[33:1]);
        div_den   = DIV_DW'(prod);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (state == ST_RISK) mem[slot] <= res_rng;
    if (state == ST_RMUL) stored <= mem[slot];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      vld              <= '0;
      frame_risk       <= RISK_SAFE;
      least_ttc        <= TTC_NONE;
      crit_brg         <= '0;
      horizon_row      <= 16'd0;
      camera_height    <= 16'd512;
      focal_length     <= 16'd16000;
      image_width      <= 13'd1920;
      critical_ttc     <= 18'd80;
      warning_distance <= 18'd1600;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_HORIZON:  horizon_row      <= cfg_data[15:0];
          CFG_HEIGHT:   camera_height    <= cfg_data[15:0];
          CFG_FOCAL:    focal_length     <= cfg_data[15:0];
          CFG_WIDTH:    image_width      <= cfg_data[12:0];
          CFG_CRIT_TTC: critical_ttc     <= cfg_data;
          CFG_WARN_RNG: warning_distance <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept && req_type == REQ_CLEAR) vld <= '0;
      if (state == ST_RISK) begin
        vld[slot] <= 1'b1;
        if (res_ttc < critical_ttc || res_rng < NEAR_RANGE) begin
          frame_risk <= RISK_CRIT;
          if (res_ttc < least_ttc) begin
            least_ttc <= res_ttc;
            crit_brg  <= res_brg;
          end
        end else if (res_rng < warning_distance && frame_risk != RISK_CRIT) begin
          frame_risk <= RISK_WARN;
        end
      end
      if (state == ST_FEND) begin
        frame_risk <= RISK_SAFE;
        least_ttc  <= TTC_NONE;
        crit_brg   <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req      <= req_type;
          id_work  <= track_no;
          left_q   <= box_left;
          right_q  <= box_right;
          bottom_q <= box_bottom;
          dt       <= frame_interval;
          res_id   <= (req_type == REQ_TRACK || req_type == REQ_LAST) ? track_no : 8'd0;
          res_rng  <= '0;
          res_brg  <= '0;
          res_spd  <= '0;
          res_ttc  <= TTC_NONE;
          res_done <= 1'b0;
          res_risk <= RISK_SAFE;
          res_rud  <= '0;
        end
      end
      // Fold the id into the slot range by repeated subtraction.
      ST_SLOT: if (slot_over) id_work <= id_work - 8'(TRACK_SLOTS);
      ST_RMUL: hist_vld <= vld[slot];
      ST_RDIV: if (dsub <= 17'sd16) res_rng <= RANGE_MAX;
      ST_RWAIT: begin
        if (div_done) res_rng <= (div_q > DIV_NW'(RANGE_MAX)) ? RANGE_MAX : div_q[17:0];
      end
      ST_BINIT: begin
        bneg <= ydiff[17];
        cy   <= $signed({4'b0, ymag, 12'b0});
        cx   <= $signed({5'b0, focal_length, 13'b0});
        ca   <= '0;
        step <= '0;
      end
      ST_CORDIC: begin
        if (cy > 34'sd0) begin
          cx <= cx + (cy >>> step);
          cy <= cy - (cx >>> step);
          ca <= ca + $signed({3'b0, cordic_angle(step)});
        end else begin
          cx <= cx - (cy >>> step);
          cy <= cy + (cx >>> step);
          ca <= ca - $signed({3'b0, cordic_angle(step)});
        end
        step <= step + 5'd1;
      end
      ST_BFIN: begin
        if (bq > BEARING_MAX) res_brg <= bneg ? -$signed(BEARING_MAX) : $signed(BEARING_MAX);
        else res_brg <= bneg ? -$signed(bq) : $signed(bq);
      end
      ST_SWAIT: begin
        if (div_done) begin
          if (div_q > DIV_NW'(SPEED_MAX))
            res_spd <= delta[18] ? -$signed({1'b0, SPEED_MAX}) : $signed({1'b0, SPEED_MAX});
          else
            res_spd <= delta[18] ? -$signed({1'b0, div_q[22:0]}) : $signed({1'b0, div_q[22:0]});
        end
      end
      ST_TMUL3: ttc_num <= {1'b0, prod, 1'b0};
      ST_TWAIT: begin
        if (div_done) res_ttc <= (div_q > DIV_NW'(TTC_NONE)) ? TTC_NONE : div_q[17:0];
      end
      ST_FEND: begin
        res_done <= 1'b1;
        res_risk <= frame_risk;
        if (frame_risk == RISK_CRIT) res_rud <= (crit_brg > 14'sd0) ? RUDDER_LEFT : RUDDER_RIGHT;
        else res_rud <= '0;
      end
      default: ;
    endcase
    if (load_out) begin
      track_no_out   <= res_id;
      range_est      <= res_rng;
      bearing_est    <= res_brg;
      closing_speed  <= res_spd;
      collision_time <= res_ttc;
      frame_done     <= res_done;
      risk_level     <= res_risk;
      rudder_hint    <= res_rud;
    end
  end

endmodule
